// ===== src/hidkbsa_pkg.sv =====
// Package for the HID boot keyboard scan assembler.
// Sizes, usage codes, the sequencer state type and the usage-to-ASCII map.
// No dependencies.
`timescale 1ns / 1ps

package hidkbsa_pkg;

  localparam int SCAN_DEPTH = 32;
  localparam int KEY_SLOTS  = 6;
  localparam int PORT_SLOTS = 6;
  localparam int FILL_W     = $clog2(SCAN_DEPTH);
  localparam int SLOT_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  localparam logic [6:0] MIN_REPORT_BYTES = 7'd8;
  localparam logic [7:0] LAST_ERROR_CODE  = 8'd3;

  localparam logic [7:0] USAGE_A     = 8'd4;
  localparam logic [7:0] USAGE_Z     = 8'd29;
  localparam logic [7:0] USAGE_1     = 8'd30;
  localparam logic [7:0] USAGE_9     = 8'd38;
  localparam logic [7:0] USAGE_0     = 8'd39;
  localparam logic [7:0] USAGE_ENTER = 8'd40;
  localparam logic [7:0] USAGE_TAB   = 8'd43;
  localparam logic [7:0] USAGE_SPACE = 8'd44;

  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_DIGIT_1 = 8'd49;
  localparam logic [6:0] ASCII_DIGIT_0 = 7'd48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_OUT,
    ST_EMPTY
  } state_t;

  // ASCII for a character usage, zero for anything else
  function automatic logic [6:0] char_of(input logic [7:0] code);
    logic [7:0] sum;
    sum = 8'd0;
    if (code == USAGE_0) begin
      sum = {1'b0, ASCII_DIGIT_0};
    end else if (code >= USAGE_1 && code <= USAGE_9) begin
      sum = ASCII_DIGIT_1 + (code - USAGE_1);
    end else if (code >= USAGE_A && code <= USAGE_Z) begin
      sum = ASCII_LOWER_A + (code - USAGE_A);
    end
    return sum[6:0];
  endfunction

  function automatic logic is_terminator(input logic [7:0] code);
    return (code == USAGE_ENTER) || (code == USAGE_TAB) || (code == USAGE_SPACE);
  endfunction

endpackage

// ===== src/hid_boot_keyboard_scan_assembler_core.sv =====
// Top level of the HID boot keyboard scan assembler.
// Depends on hidkbsa_pkg and hidkbsa_ram (character store).
`timescale 1ns / 1ps

// Accepts boot keyboard reports and clear transactions on the input channel and
// turns key releases into a scan string. Clear transactions and reports shorter
// than 8 bytes finish in the accept cycle. For a full report the sequencer checks
// one previous key a cycle, up to the 6 key slots, and writes released characters
// into the 32-entry character store. When a terminator (enter, tab, space)
// completes the scan, each character of the run is read from the store (registered
// RAM read) and then given as an output transaction, which may stall; an empty
// scan gives one result. No new input transaction is taken until the run has been
// delivered.
module hid_boot_keyboard_scan_assembler_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [6:0] report_length,
  input  logic [7:0] key_slot0,
  input  logic [7:0] key_slot1,
  input  logic [7:0] key_slot2,
  input  logic [7:0] key_slot3,
  input  logic [7:0] key_slot4,
  input  logic [7:0] key_slot5,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] scan_char,
  output logic       last,
  output logic       empty_scan
);

  localparam int FW = hidkbsa_pkg::FILL_W;
  localparam int SW = hidkbsa_pkg::SLOT_W;
  localparam int NS = hidkbsa_pkg::KEY_SLOTS;

  hidkbsa_pkg::state_t state, state_next;

  logic [7:0]    previous_keys [NS];
  logic [7:0]    now_keys      [NS];
  logic [7:0]    port_keys     [hidkbsa_pkg::PORT_SLOTS];
  logic [FW-1:0] fill_index;
  logic          ready_hold;
  logic [SW-1:0] slot_idx;
  logic [FW-1:0] run_len;
  logic [FW-1:0] emit_idx;

  logic          in_fire, out_fire;
  logic          take_report;
  logic [7:0]    old_key;
  logic          held_in_now;
  logic          act;
  logic          term_hit;
  logic [6:0]    ch;
  logic          last_slot;
  logic          run_end;

  logic          ram_we, ram_re;
  logic [6:0]    ram_rdata;

  assign port_keys[0] = key_slot0;
  assign port_keys[1] = key_slot1;
  assign port_keys[2] = key_slot2;
  assign port_keys[3] = key_slot3;
  assign port_keys[4] = key_slot4;
  assign port_keys[5] = key_slot5;

  assign in_fire     = in_valid && in_ready;
  assign out_fire    = out_valid && out_ready;
  assign take_report = in_fire && !func && (report_length >= hidkbsa_pkg::MIN_REPORT_BYTES);

  // one previous key per scan cycle, matched against all new slots at once
  assign old_key = previous_keys[slot_idx];
  always_comb begin
    held_in_now = 1'b0;
    for (int j = 0; j < NS; j++) begin
      if (now_keys[j] == old_key) begin
        held_in_now = 1'b1;
      end
    end
  end

  assign ch        = hidkbsa_pkg::char_of(old_key);
  assign act       = (old_key > hidkbsa_pkg::LAST_ERROR_CODE) && !held_in_now && !ready_hold;
  assign term_hit  = act && hidkbsa_pkg::is_terminator(old_key);
  assign last_slot = (slot_idx == SW'(NS - 1));
  assign run_end   = ((emit_idx + FW'(1)) == run_len);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hidkbsa_pkg::ST_IDLE: begin
        if (take_report) begin
          state_next = hidkbsa_pkg::ST_SCAN;
        end
      end
      hidkbsa_pkg::ST_SCAN: begin
        if (term_hit) begin
          state_next = (fill_index == '0) ? hidkbsa_pkg::ST_EMPTY : hidkbsa_pkg::ST_READ;
        end else if (last_slot) begin
          state_next = hidkbsa_pkg::ST_IDLE;
        end
      end
      hidkbsa_pkg::ST_READ: begin
        state_next = hidkbsa_pkg::ST_OUT;
      end
      hidkbsa_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next = run_end ? hidkbsa_pkg::ST_IDLE : hidkbsa_pkg::ST_READ;
        end
      end
      hidkbsa_pkg::ST_EMPTY: begin
        if (out_ready) begin
          state_next = hidkbsa_pkg::ST_IDLE;
        end
      end
      default: state_next = hidkbsa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    scan_char  = ram_rdata;
    last       = 1'b0;
    empty_scan = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state)
      hidkbsa_pkg::ST_IDLE: in_ready = 1'b1;
      hidkbsa_pkg::ST_SCAN: ram_we = act && !term_hit && (ch != 7'd0);
      hidkbsa_pkg::ST_READ: ram_re = 1'b1;
      hidkbsa_pkg::ST_OUT: begin
        out_valid = 1'b1;
        last      = run_end;
      end
      hidkbsa_pkg::ST_EMPTY: begin
        out_valid  = 1'b1;
        scan_char  = 7'd0;
        last       = 1'b1;
        empty_scan = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hidkbsa_pkg::ST_IDLE;
      fill_index <= '0;
      ready_hold <= 1'b0;
      for (int j = 0; j < NS; j++) begin
        previous_keys[j] <= 8'd0;
      end
    end else begin
      state <= state_next;
      case (state)
        hidkbsa_pkg::ST_IDLE: begin
          if (in_fire && func) begin
            ready_hold <= 1'b0;
          end
        end
        hidkbsa_pkg::ST_SCAN: begin
          if (term_hit) begin
            ready_hold <= 1'b1;
            fill_index <= '0;
          end else if (ram_we) begin
            fill_index <= (fill_index == FW'(hidkbsa_pkg::SCAN_DEPTH - 1)) ? '0
                                                                     : fill_index + FW'(1);
          end
          // later slots cannot act once the hold is set, so the copy can go early
          if (term_hit || last_slot) begin
            for (int j = 0; j < NS; j++) begin
              previous_keys[j] <= now_keys[j];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state)
      hidkbsa_pkg::ST_IDLE: begin
        slot_idx <= '0;
        if (take_report) begin
          for (int j = 0; j < NS; j++) begin
            now_keys[j] <= port_keys[j];
          end
        end
      end
      hidkbsa_pkg::ST_SCAN: begin
        slot_idx <= slot_idx + SW'(1);
        if (term_hit) begin
          run_len  <= fill_index;
          emit_idx <= '0;
        end
      end
      hidkbsa_pkg::ST_OUT: begin
        if (out_ready && !run_end) begin
          emit_idx <= emit_idx + FW'(1);
        end
      end
      default: ;
    endcase
  end

  hidkbsa_ram #(
    .WIDTH (7),
    .DEPTH (hidkbsa_pkg::SCAN_DEPTH)
  ) u_char_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_index),
    .wdata (ch),
    .re    (ram_re),
    .raddr (emit_idx),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_scan) |-> (last && (scan_char == 7'd0)))
    else $error("empty scan result malformed");

  a_hold_during_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ready_hold && (fill_index == '0)))
    else $error("run emitted without hold set or with fill count left");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !last) |=> (!in_ready && (state == hidkbsa_pkg::ST_READ)))
    else $error("run ended before last marker");

  a_clear_hold: assert property (@(posedge clk) disable iff (rst)
    (in_fire && func) |=> !ready_hold)
    else $error("clear transaction did not drop hold");
`endif

endmodule

// ===== src/hidkbsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; read data holds until the next read enable.
`timescale 1ns / 1ps

module hidkbsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
